// ===== hdl/crcfr_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the command framer.
// No dependencies; every other file of the block imports this package.
package crcfr_pkg;

  // Frame limit on command and response lengths, in bytes
  localparam int unsigned FRAME_LIMIT = 256;
  // CRC-16 generator polynomial, data taken LSB first, seed zero
  localparam logic [15:0] CRC_POLY = 16'h8005;
  // Word address byte placed before each command after reset
  localparam logic [7:0] CMD_HEADER_RESET = 8'h03;
  // Words of one queued job and their index width
  localparam int unsigned JOB_WORDS = 5;
  localparam int unsigned JOB_IDX_W = $clog2(JOB_WORDS);
  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Input function codes
  localparam logic FUNC_TX = 1'b0;
  localparam logic FUNC_RX = 1'b1;

  // Result kind codes
  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

  // One job: up to five result words that share kind and status
  typedef struct packed {
    logic                            kind;
    logic [1:0]                      status;
    logic                            last_flag;  // mark the final word last
    logic [JOB_IDX_W:0]              cnt;        // words in this job, 1 to 5
    logic [JOB_WORDS-1:0][7:0]       bytes;      // bytes[0] goes out first
  } crcfr_job_t;

  // Advance the CRC by one byte, bit 0 first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (data[i] ^ c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/crcfr_front.sv =====
// Front end: accepts input words, keeps transmit and receive frame state,
// computes the CRC and turns each word into at most one queued job. Uses crcfr_pkg.
module crcfr_front import crcfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_func,
  input  logic [7:0]       in_data_in,
  input  logic [7:0]       in_cmd_length,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_command_header,
  input  logic             q_full,
  output logic             q_push,
  output crcfr_job_t       q_push_job
);

  logic [7:0]  hdr_r, hdr_nxt;
  logic [15:0] tx_crc_r, tx_crc_nxt;
  logic [7:0]  tx_rem_r, tx_rem_nxt;
  logic        tx_drop_r, tx_drop_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [7:0]  rx_cnt_r, rx_cnt_nxt;
  logic [7:0]  rx_idx_r, rx_idx_nxt;
  logic [7:0]  rx_first_r, rx_first_nxt;
  logic [7:0]  rx_lo_r, rx_lo_nxt;

  logic        accept;
  logic [7:0]  len_eff;
  logic [9:0]  len_sum;
  logic        too_long;
  logic [7:0]  len_byte;
  logic [7:0]  len_m1;
  logic [7:0]  rem_m1;
  logic [15:0] crc_first;
  logic [15:0] crc_cont;
  logic [8:0]  rx_idx_p1;
  logic [8:0]  rx_idx_p2;
  logic [8:0]  rx_cnt9;
  logic        rx_bad_cnt;
  logic        rx_crc_ok;
  crcfr_job_t  job;
  logic        job_valid;

  // Take a word whenever the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Length arithmetic for the first byte of a command
  assign len_eff   = (in_cmd_length == 8'd0) ? 8'd1 : in_cmd_length;
  assign len_sum   = {2'b00, len_eff} + 10'd4;
  assign too_long  = len_sum >= 10'(FRAME_LIMIT);
  assign len_byte  = len_eff + 8'd3;
  assign len_m1    = len_eff - 8'd1;
  assign rem_m1    = tx_rem_r - 8'd1;
  assign crc_first = crc16_byte(crc16_byte(16'h0000, len_byte), in_data_in);
  assign crc_cont  = crc16_byte(tx_crc_r, in_data_in);

  // Response position arithmetic
  assign rx_idx_p1  = {1'b0, rx_idx_r} + 9'd1;
  assign rx_idx_p2  = {1'b0, rx_idx_r} + 9'd2;
  assign rx_cnt9    = {1'b0, rx_cnt_r};
  assign rx_bad_cnt = (rx_cnt_r < 8'd3) || (rx_cnt9 >= 9'(FRAME_LIMIT));
  assign rx_crc_ok  = (rx_crc_r[7:0] == rx_lo_r) && (rx_crc_r[15:8] == in_data_in);

  // Classify the word and build its job
  always_comb begin
    hdr_nxt      = cfg_wr_en ? cfg_command_header : hdr_r;
    tx_crc_nxt   = tx_crc_r;
    tx_rem_nxt   = tx_rem_r;
    tx_drop_nxt  = tx_drop_r;
    rx_crc_nxt   = rx_crc_r;
    rx_cnt_nxt   = rx_cnt_r;
    rx_idx_nxt   = rx_idx_r;
    rx_first_nxt = rx_first_r;
    rx_lo_nxt    = rx_lo_r;
    job          = '0;
    job_valid    = 1'b0;
    if (accept) begin
      if (in_func == FUNC_TX) begin
        job.kind   = KIND_TX;
        job.status = STATUS_OK;
        if (tx_rem_r == 8'd0) begin
          tx_rem_nxt = len_m1;
          job_valid  = 1'b1;
          if (too_long) begin
            // One length error, then drop the rest of the command
            tx_drop_nxt   = (len_m1 != 8'd0);
            job.status    = STATUS_LEN_ERR;
            job.last_flag = 1'b1;
            job.cnt       = (JOB_IDX_W+1)'(1);
            job.bytes[0]  = 8'd0;
          end else begin
            tx_drop_nxt   = 1'b0;
            tx_crc_nxt    = crc_first;
            job.bytes[0]  = hdr_r;
            job.bytes[1]  = len_byte;
            job.bytes[2]  = in_data_in;
            job.bytes[3]  = crc_first[7:0];
            job.bytes[4]  = crc_first[15:8];
            job.last_flag = (len_m1 == 8'd0);
            job.cnt       = (len_m1 == 8'd0) ? (JOB_IDX_W+1)'(5) : (JOB_IDX_W+1)'(3);
          end
        end else if (tx_drop_r) begin
          // Swallow a byte of an over-long command
          tx_rem_nxt  = rem_m1;
          tx_drop_nxt = (rem_m1 != 8'd0);
        end else begin
          tx_crc_nxt    = crc_cont;
          tx_rem_nxt    = rem_m1;
          job_valid     = 1'b1;
          job.bytes[0]  = in_data_in;
          job.bytes[1]  = crc_cont[7:0];
          job.bytes[2]  = crc_cont[15:8];
          job.last_flag = (rem_m1 == 8'd0);
          job.cnt       = (rem_m1 == 8'd0) ? (JOB_IDX_W+1)'(3) : (JOB_IDX_W+1)'(1);
        end
      end else begin
        job.kind      = KIND_RX;
        job.last_flag = 1'b1;
        job.cnt       = (JOB_IDX_W+1)'(1);
        if (rx_idx_r == 8'd0) begin
          // Count byte opens the response
          rx_cnt_nxt   = in_data_in;
          rx_crc_nxt   = crc16_byte(16'h0000, in_data_in);
          rx_first_nxt = 8'd0;
          rx_lo_nxt    = 8'd0;
          if (in_data_in <= 8'd1) begin
            job_valid    = 1'b1;
            job.status   = STATUS_LEN_ERR;
            job.bytes[0] = 8'd0;
          end else begin
            rx_idx_nxt = 8'd1;
          end
        end else begin
          if (rx_idx_r == 8'd1) begin
            rx_first_nxt = in_data_in;
          end
          if (rx_idx_p2 < rx_cnt9) begin
            rx_crc_nxt = crc16_byte(rx_crc_r, in_data_in);
          end
          if (rx_idx_p2 == rx_cnt9) begin
            rx_lo_nxt = in_data_in;
          end
          if (rx_idx_p1 >= rx_cnt9) begin
            // Final byte: report the check
            rx_idx_nxt = 8'd0;
            job_valid  = 1'b1;
            if (rx_bad_cnt) begin
              job.status   = STATUS_LEN_ERR;
              job.bytes[0] = 8'd0;
            end else begin
              job.status   = rx_crc_ok ? STATUS_OK : STATUS_CRC_ERR;
              job.bytes[0] = rx_first_r;
            end
          end else begin
            rx_idx_nxt = rx_idx_p1[7:0];
          end
        end
      end
    end
  end

  assign q_push     = job_valid;
  assign q_push_job = job;

  // Hold control state across words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= CMD_HEADER_RESET;
      tx_crc_r   <= '0;
      tx_rem_r   <= '0;
      tx_drop_r  <= 1'b0;
      rx_crc_r   <= '0;
      rx_cnt_r   <= '0;
      rx_idx_r   <= '0;
      rx_first_r <= '0;
      rx_lo_r    <= '0;
    end else begin
      hdr_r      <= hdr_nxt;
      tx_crc_r   <= tx_crc_nxt;
      tx_rem_r   <= tx_rem_nxt;
      tx_drop_r  <= tx_drop_nxt;
      rx_crc_r   <= rx_crc_nxt;
      rx_cnt_r   <= rx_cnt_nxt;
      rx_idx_r   <= rx_idx_nxt;
      rx_first_r <= rx_first_nxt;
      rx_lo_r    <= rx_lo_nxt;
    end
  end

  // Dropping only happens while bytes of the command remain
  a_drop_needs_rem: assert property (@(posedge clk) disable iff (!rst_n)
    tx_drop_r |-> (tx_rem_r != 8'd0))
    else $error("drop flag set with no command bytes left");

  // An open response always sits before its end
  a_rx_inside_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_idx_r != 8'd0) |-> (rx_idx_r < rx_cnt_r))
    else $error("response position past its count");

endmodule

// ===== hdl/crcfr_queue.sv =====
// Short job queue between the front and back ends of the command framer.
// Uses crcfr_pkg for the job type.
module crcfr_queue import crcfr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  crcfr_job_t push_job,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output crcfr_job_t head_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  crcfr_job_t         slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store jobs; no reset on payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("job queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("job pushed into a full queue");

endmodule

// ===== hdl/crcfr_back.sv =====
// Back end: expands each queued job into result words, one per cycle while
// out_ready allows, through a registered output stage. Uses crcfr_pkg.
module crcfr_back import crcfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  crcfr_job_t head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic                 valid_r, valid_nxt;
  logic [JOB_IDX_W-1:0] idx_r, idx_nxt;
  logic                 kind_r;
  logic [7:0]           byte_r;
  logic [1:0]           status_r;
  logic                 last_r;
  logic                 load;
  logic                 final_word;

  // Load a word when the output stage is free or being emptied
  assign load       = head_valid && (!valid_r || out_ready);
  assign final_word = ({1'b0, idx_r} == head_job.cnt - (JOB_IDX_W+1)'(1));
  assign pop        = load && final_word;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = final_word ? '0 : idx_r + JOB_IDX_W'(1);
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= head_job.kind;
      byte_r   <= head_job.bytes[idx_r];
      status_r <= head_job.status;
      last_r   <= final_word && head_job.last_flag;
    end
  end

  assign out_valid    = valid_r;
  assign out_kind     = kind_r;
  assign out_out_byte = byte_r;
  assign out_status   = status_r;
  assign out_last     = last_r;

  // A job in progress stays at the queue head and within its length
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> (head_valid && ({1'b0, idx_r} < head_job.cnt)))
    else $error("word index outside the current job");

endmodule

// ===== hdl/crc16_command_framer_and_checker.sv =====
// Top level of the CRC-16 command framer and response checker.
// Instantiates crcfr_front, crcfr_queue and crcfr_back; uses crcfr_pkg.
//
// Transmit words (func 0) are framed as header, length, data, then CRC low
// and high bytes with last set; over-long commands give one length error and
// their remaining bytes are dropped. Receive words (func 1) give one check
// result per response frame. One input word is accepted per cycle while the
// job queue (QUEUE_DEPTH entries) has room; each word becomes at most one
// job of one to five result words, and the output register sends one result
// word per cycle while out_ready is high. A command's first byte therefore
// gives three result words (five for a one-byte command), its last byte its
// data and two CRC words, middle bytes one, and a response one word at its
// end. A result word passes through the job queue, then the output register.
// The command_header register is written at any edge with cfg_wr_en high.
module crc16_command_framer_and_checker import crcfr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_data_in,
  input  logic [7:0] in_cmd_length,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_out_byte,
  output logic [1:0] out_status,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_command_header
);

  logic       q_full;
  logic       q_push;
  crcfr_job_t q_push_job;
  logic       q_pop;
  logic       q_head_valid;
  crcfr_job_t q_head_job;

  // Classify input words into jobs
  crcfr_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_data_in         (in_data_in),
    .in_cmd_length      (in_cmd_length),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_command_header (cfg_command_header),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_push_job         (q_push_job)
  );

  // Decouple front and back
  crcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // Emit result words
  crcfr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_head_valid),
    .head_job     (q_head_job),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_out_byte (out_out_byte),
    .out_status   (out_status),
    .out_last     (out_last)
  );

endmodule
